@@ sv/motor_speed_command_conditioner_top_macros.svh @@
// Assertion macros used by the conditioner controller.
`ifndef MOTOR_SPEED_COMMAND_CONDITIONER_TOP_MACROS_SVH
`define MOTOR_SPEED_COMMAND_CONDITIONER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/msc_pkg.sv @@
// Shared types, register indexes and constants of the speed command conditioner.
package msc_pkg;

  localparam int DivSteps = 17;
  localparam int CntW     = $clog2(DivSteps);

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t RegUseDirect  = 3'd0;
  localparam reg_idx_t RegLimits     = 3'd1;
  localparam reg_idx_t RegSpeedMin   = 3'd2;
  localparam reg_idx_t RegSpeedMax   = 3'd3;
  localparam reg_idx_t RegDutyMax    = 3'd4;
  localparam reg_idx_t RegSerialMax  = 3'd5;
  localparam reg_idx_t RegOutputMode = 3'd6;

  typedef struct packed {
    logic signed [15:0] pid_speed;
    logic signed [15:0] target_speed;
    logic               activated;
    logic               at_lower_limit;
    logic               at_upper_limit;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] speed_command;
    logic [15:0]        pwm_duty;
    logic               direction;
    logic signed [15:0] serial_rpm;
    logic               serial_valid;
  } out_item_t;

  typedef struct packed {
    logic        use_direct_target;
    logic        limits_apply;
    logic [14:0] speed_min;
    logic [14:0] speed_max;
    logic [15:0] duty_max;
    logic [14:0] serial_speed_max;
    logic        output_mode;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

endpackage

@@ sv/msc_cfg.sv @@
// Configuration register file of the speed command conditioner.
module msc_cfg import msc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        RegUseDirect:  cfg_nxt.use_direct_target = cfg_data[0];
        RegLimits:     cfg_nxt.limits_apply      = cfg_data[0];
        RegSpeedMin:   cfg_nxt.speed_min         = cfg_data[14:0];
        RegSpeedMax:   cfg_nxt.speed_max         = cfg_data[14:0];
        RegDutyMax:    cfg_nxt.duty_max          = cfg_data;
        RegSerialMax:  cfg_nxt.serial_speed_max  = cfg_data[14:0];
        RegOutputMode: cfg_nxt.output_mode       = cfg_data[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{use_direct_target: 1'b0, limits_apply: 1'b0, speed_min: 15'd0,
                 speed_max: 15'h7fff, duty_max: 16'd0, serial_speed_max: 15'd0,
                 output_mode: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ sv/msc_dp.sv @@
// Datapath: source select, gating, clamp, multiply and bit-serial scale divide.
module msc_dp import msc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  logic        neg_r;
  logic [14:0] mag_r;
  logic [30:0] acc_r;
  logic [30:0] den_r;
  logic [16:0] quo_r;
  logic        last_dir_r;
  out_item_t   out_r;

  logic signed [15:0] sel_speed;
  logic               force_zero;
  logic [15:0]        abs_speed;
  logic [14:0]        mag_nxt;
  logic [14:0]        divisor;
  logic [15:0]        factor;
  logic               ge;
  logic [15:0]        duty;
  logic signed [15:0] rpm;
  logic signed [15:0] speed_cmd;

  always_comb begin
    sel_speed  = cfg.use_direct_target ? in_data.target_speed : in_data.pid_speed;
    force_zero = !in_data.activated ||
                 (cfg.limits_apply && (in_data.at_lower_limit || in_data.at_upper_limit));
    if (force_zero) begin
      sel_speed = '0;
    end
    abs_speed = sel_speed[15] ? 16'(-sel_speed) : 16'(sel_speed);
    // Raise to the minimum first so that it wins over the maximum.
    if (abs_speed == 16'd0) begin
      mag_nxt = '0;
    end else if (abs_speed < {1'b0, cfg.speed_min}) begin
      mag_nxt = cfg.speed_min;
    end else if (abs_speed > {1'b0, cfg.speed_max}) begin
      mag_nxt = cfg.speed_max;
    end else begin
      mag_nxt = abs_speed[14:0];
    end
  end

  assign divisor = (cfg.speed_max == 15'd0) ? 15'd1 : cfg.speed_max;
  assign factor  = cfg.output_mode ? {1'b0, cfg.serial_speed_max} : cfg.duty_max;
  assign ge      = acc_r >= den_r;

  always_comb begin
    speed_cmd = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
    duty      = quo_r[16] ? 16'hffff : quo_r[15:0];
    if (neg_r) begin
      rpm = (quo_r > 17'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, quo_r[15:0]}));
    end else begin
      rpm = (quo_r > 17'd32767) ? 16'sh7fff : $signed(quo_r[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= sel_speed[15];
      mag_r <= mag_nxt;
    end
    if (cmd.mul) begin
      acc_r <= {16'd0, mag_r} * {15'd0, factor};
      den_r <= {divisor, 16'd0};
      quo_r <= '0;
    end
    // One quotient bit per step, most significant first.
    if (cmd.step) begin
      if (ge) begin
        acc_r <= acc_r - den_r;
      end
      quo_r <= {quo_r[15:0], ge};
      den_r <= den_r >> 1;
    end
    if (cmd.finish) begin
      out_r.speed_command <= speed_cmd;
      if (cfg.output_mode) begin
        out_r.pwm_duty     <= '0;
        out_r.direction    <= last_dir_r;
        out_r.serial_rpm   <= rpm;
        out_r.serial_valid <= 1'b1;
      end else begin
        out_r.pwm_duty     <= duty;
        out_r.direction    <= (mag_r != 15'd0) ? !neg_r : last_dir_r;
        out_r.serial_rpm   <= '0;
        out_r.serial_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dir_r <= 1'b0;
    end else if (cmd.finish && !cfg.output_mode && mag_r != 15'd0) begin
      last_dir_r <= !neg_r;
    end
  end

  assign out_data = out_r;

endmodule

@@ sv/msc_ctrl.sv @@
// Controller state machine: sequences load, multiply, divide and result hand-off.
module msc_ctrl import msc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  `include "motor_speed_command_conditioner_top_macros.svh"

  state_t          state_r;
  state_t          state_nxt;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == CntW'(DivSteps - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        // Hold until the result register is free.
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.finish ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MSC_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == S_MUL && in_stall, "accepted item did not start the multiply")
  `MSC_ASSERT_NOW(a_cnt_bound, state_r == S_DIV, cnt_r <= CntW'(DivSteps - 1), "divide step counter out of range")
  `MSC_ASSERT_NEXT(a_fin_holds, state_r == S_FIN && out_valid_r && out_stall, state_r == S_FIN && out_valid_r, "finished item overwrote a pending result")
  `MSC_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_r, "finished item not presented")

endmodule

@@ sv/motor_speed_command_conditioner_top.sv @@
// Motor speed command conditioner: top level joining registers, controller and datapath.
// Steps: load at accept, multiply, 17 bit-serial scale divide steps, and finish when
// the result register is free; in_stall holds off a new item until the last is finished.
// A new item is taken while the previous result still waits on out_stall.
// Reset (rst_n low, synchronous) loads register defaults, clears direction to backward
// and empties the result register.
module motor_speed_command_conditioner_top import msc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  msc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  msc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
